>>> hdl/infix_to_postfix_converter_macros.svh
// Assertion macros for the infix to postfix converter.
`ifndef INFIX_TO_POSTFIX_CONVERTER_MACROS_SVH
`define INFIX_TO_POSTFIX_CONVERTER_MACROS_SVH
`ifndef SYNTH
`define ITP_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("itp assertion failed");
`define ITP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("itp assertion failed");
`else
`define ITP_ASSERT_SAME(label, ante, cons)
`define ITP_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> hdl/itp_pkg.sv
// Shared types, constants and helpers of the infix to postfix converter.
`default_nettype none
package itp_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int PTR_W = $clog2(STACK_DEPTH);

  typedef logic [2:0] entry_t;
  localparam entry_t LPAREN_MARK = 3'd4;

  localparam logic [2:0] MODE_NUM    = 3'd0;
  localparam logic [2:0] MODE_OP     = 3'd1;
  localparam logic [2:0] MODE_LPAREN = 3'd2;
  localparam logic [2:0] MODE_RPAREN = 3'd3;
  localparam logic [2:0] MODE_END    = 3'd4;

  localparam logic [1:0] KIND_NUM = 2'd0;
  localparam logic [1:0] KIND_OP  = 2'd1;
  localparam logic [1:0] KIND_END = 2'd2;
  localparam logic [1:0] KIND_OVF = 2'd3;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [31:0] number_value;
    logic [1:0]         op_code;
  } in_t;

  typedef struct packed {
    logic [1:0]         out_kind;
    logic signed [31:0] out_value;
    logic [1:0]         out_op;
    logic               last;
  } out_t;

  typedef struct packed {
    logic             rd_en;
    logic [PTR_W-1:0] rd_addr;
    logic             wr_en;
    logic [PTR_W-1:0] wr_addr;
    entry_t           wr_data;
  } ram_req_t;

  typedef struct packed {
    logic             busy;
    logic [CNT_W-1:0] cnt;
  } seq_status_t;

  // true when the stacked operator binds at least as tightly as the incoming one
  function automatic logic prec_le(logic [1:0] op, entry_t t);
    return !(op[1] && !t[1]);
  endfunction

  function automatic out_t mk_result(logic [1:0] kind, logic signed [31:0] value,
                                     logic [1:0] op, logic last);
    out_t r;
    r.out_kind  = kind;
    r.out_value = value;
    r.out_op    = op;
    r.last      = last;
    return r;
  endfunction

endpackage
`default_nettype wire

>>> hdl/infix_to_postfix_converter.sv
// Top level of the infix to postfix converter: output register and sequencer hookup.
//
//   channel  direction  handshake           beat
//   in       to block   in_valid/in_stall   itp_pkg::in_t  (one infix token)
//   out      from block out_valid/out_stall itp_pkg::out_t (one postfix token)
//
// A token is taken in while idle and then handled in steps: a number or push takes one,
// each popped operator adds one, and a final result after popped operators adds one.
// The stack RAM read port sets the pace: one pop per cycle unless the output stalls;
// read data comes next cycle. Reset clears the stack count but not the RAM.
// A stalled output holds the sequencer; new tokens wait until the current one is done.
`default_nettype none
`include "infix_to_postfix_converter_macros.svh"
module infix_to_postfix_converter (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire itp_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output itp_pkg::out_t      out_data
);

  itp_pkg::ram_req_t    req;
  itp_pkg::entry_t      rd_data;
  itp_pkg::out_t        out_beat;
  itp_pkg::seq_status_t status;
  logic                 out_load;
  logic                 can_emit;

  assign can_emit = !out_valid || !out_stall;
  assign in_stall = status.busy;

  itp_stack_ram u_ram (
    .clk     (clk),
    .req     (req),
    .rd_data (rd_data)
  );

  itp_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_data  (in_data),
    .can_emit (can_emit),
    .rd_data  (rd_data),
    .req      (req),
    .out_load (out_load),
    .out_beat (out_beat),
    .status   (status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= out_beat;
    end
  end

  `ITP_ASSERT_SAME(a_cnt_range, 1'b1, status.cnt <= itp_pkg::CNT_W'(itp_pkg::STACK_DEPTH))
  `ITP_ASSERT_SAME(a_load_free, out_load, can_emit)
  `ITP_ASSERT_NEXT(a_accept_busy, in_valid && !in_stall, in_stall)
  `ITP_ASSERT_SAME(a_no_rw_clash, req.rd_en && req.wr_en, 1'b0)

endmodule
`default_nettype wire

>>> hdl/itp_stack_ram.sv
// Operator stack storage: one write port, one registered read port.
`default_nettype none
module itp_stack_ram (
  input  wire logic              clk,
  input  wire itp_pkg::ram_req_t req,
  output itp_pkg::entry_t        rd_data
);

  itp_pkg::entry_t mem [itp_pkg::STACK_DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule
`default_nettype wire

>>> hdl/itp_seq.sv
// Token sequencer: top-of-stack register, stack count and result ordering.
`default_nettype none
module itp_seq (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire itp_pkg::in_t         in_data,
  input  wire logic                 can_emit,
  input  wire itp_pkg::entry_t      rd_data,
  output itp_pkg::ram_req_t         req,
  output logic                      out_load,
  output itp_pkg::out_t             out_beat,
  output itp_pkg::seq_status_t      status
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_WORK  = 3'b010,
    S_CLOSE = 3'b100
  } state_t;

  state_t                     state, state_next;
  itp_pkg::in_t               item;
  logic [itp_pkg::CNT_W-1:0]  cnt, cnt_next;
  itp_pkg::entry_t            top, top_next;
  logic                       from_ram, from_ram_next;
  itp_pkg::out_t              pend, pend_next;
  logic                       pend_valid, pend_valid_next;

  itp_pkg::entry_t            eff_top;
  logic                       have_top, not_lp, full, step;
  logic [itp_pkg::CNT_W-1:0]  cnt_m1, cnt_m2;
  logic                       act_pop, act_emit, act_push, act_fin, act_clear, fin_v;
  itp_pkg::entry_t            push_val;
  itp_pkg::out_t              emit_res, fin_res;

  assign eff_top  = from_ram ? rd_data : top;
  assign have_top = cnt != '0;
  assign not_lp   = eff_top != itp_pkg::LPAREN_MARK;
  assign full     = cnt == itp_pkg::CNT_W'(itp_pkg::STACK_DEPTH);
  assign cnt_m1   = cnt - itp_pkg::CNT_W'(1);
  assign cnt_m2   = cnt - itp_pkg::CNT_W'(2);
  assign step     = (state == S_WORK) && can_emit;

  // decode one step of the current token
  always_comb begin
    act_pop   = 1'b0;
    act_emit  = 1'b0;
    act_push  = 1'b0;
    act_fin   = 1'b0;
    act_clear = 1'b0;
    fin_v     = 1'b0;
    push_val  = itp_pkg::entry_t'(item.op_code);
    emit_res  = itp_pkg::mk_result(itp_pkg::KIND_OP, 32'sd0, eff_top[1:0], 1'b0);
    fin_res   = itp_pkg::mk_result(itp_pkg::KIND_OVF, 32'sd0, 2'd0, 1'b1);
    if (step) begin
      case (item.mode)
        itp_pkg::MODE_NUM: begin
          act_fin = 1'b1;
          fin_v   = 1'b1;
          fin_res = itp_pkg::mk_result(itp_pkg::KIND_NUM, item.number_value, 2'd0, 1'b1);
        end
        itp_pkg::MODE_OP: begin
          if (have_top && not_lp && itp_pkg::prec_le(item.op_code, eff_top)) begin
            act_pop  = 1'b1;
            act_emit = 1'b1;
          end else if (!full) begin
            act_push = 1'b1;
            act_fin  = 1'b1;
          end else begin
            act_fin = 1'b1;
            fin_v   = 1'b1;
          end
        end
        itp_pkg::MODE_LPAREN: begin
          push_val = itp_pkg::LPAREN_MARK;
          act_fin  = 1'b1;
          act_push = !full;
          fin_v    = full;
        end
        itp_pkg::MODE_RPAREN: begin
          act_pop = have_top;
          if (have_top && not_lp) begin
            act_emit = 1'b1;
          end else begin
            act_fin = 1'b1;
          end
        end
        itp_pkg::MODE_END: begin
          if (have_top && not_lp) begin
            act_pop  = 1'b1;
            act_emit = 1'b1;
          end else begin
            act_clear = 1'b1;
            act_fin   = 1'b1;
            fin_v     = 1'b1;
            fin_res   = itp_pkg::mk_result(itp_pkg::KIND_END, 32'sd0, 2'd0, 1'b1);
          end
        end
        default: begin
          act_fin = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    top_next        = eff_top;
    from_ram_next   = 1'b0;
    pend_next       = pend;
    pend_valid_next = pend_valid;
    out_load        = 1'b0;
    out_beat        = pend;
    req             = '0;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_WORK;
        end
      end
      S_WORK: begin
        if (act_pop) begin
          cnt_next = cnt_m1;
          if (cnt > itp_pkg::CNT_W'(1)) begin
            req.rd_en     = 1'b1;
            req.rd_addr   = cnt_m2[itp_pkg::PTR_W-1:0];
            from_ram_next = 1'b1;
          end
        end
        if (act_push) begin
          if (have_top) begin
            req.wr_en   = 1'b1;
            req.wr_addr = cnt_m1[itp_pkg::PTR_W-1:0];
            req.wr_data = eff_top;
          end
          top_next = push_val;
          cnt_next = cnt + itp_pkg::CNT_W'(1);
        end
        if (act_clear) begin
          cnt_next = '0;
        end
        if (act_emit) begin
          out_load        = pend_valid;
          pend_next       = emit_res;
          pend_valid_next = 1'b1;
        end
        if (act_fin) begin
          if (fin_v) begin
            if (pend_valid) begin
              out_load   = 1'b1;
              pend_next  = fin_res;
              state_next = S_CLOSE;
            end else begin
              out_load   = 1'b1;
              out_beat   = fin_res;
              state_next = S_IDLE;
            end
          end else begin
            out_load        = pend_valid;
            out_beat.last   = 1'b1;
            pend_valid_next = 1'b0;
            state_next      = S_IDLE;
          end
        end
      end
      S_CLOSE: begin
        if (can_emit) begin
          out_load        = 1'b1;
          pend_valid_next = 1'b0;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cnt        <= '0;
      from_ram   <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      state      <= state_next;
      cnt        <= cnt_next;
      from_ram   <= from_ram_next;
      pend_valid <= pend_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    top  <= top_next;
    pend <= pend_next;
    if (state == S_IDLE && in_valid) begin
      item <= in_data;
    end
  end

  assign status.busy = state != S_IDLE;
  assign status.cnt  = cnt;

endmodule
`default_nettype wire

>>> test/testbench.sv
// Self-checking testbench for the shunting-yard infix to postfix converter.
`timescale 1ns / 100ps
module testbench;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TOKEN_TARGET = 220;
  localparam int LONG_HOLD = 400;

  class postfix_scoreboard;
    itp_pkg::entry_t held_ops[itp_pkg::STACK_DEPTH];
    int unsigned     held_cnt;
    itp_pkg::out_t   postfix_q[$];
    int unsigned     err_count;

    function new();
      held_cnt = 0;
      err_count = 0;
    endfunction

    function int unsigned bind_rank(logic [1:0] op);
      return op[1] ? 3 : 2;
    endfunction

    function itp_pkg::out_t make_beat(logic [1:0] kind, logic signed [31:0] val,
                                      logic [1:0] op);
      itp_pkg::out_t b;
      b.out_kind = kind;
      b.out_value = val;
      b.out_op = op;
      b.last = 1'b0;
      return b;
    endfunction

    function int unsigned pending();
      return postfix_q.size();
    endfunction

    function void note_token(itp_pkg::in_t t);
      itp_pkg::out_t   res[$];
      itp_pkg::entry_t top;
      case (t.mode) inside
        itp_pkg::MODE_NUM: res = {res, make_beat(itp_pkg::KIND_NUM, t.number_value, 2'd0)};
        itp_pkg::MODE_OP: begin
          while (held_cnt > 0) begin
            top = held_ops[held_cnt-1];
            if (top == itp_pkg::LPAREN_MARK || bind_rank(t.op_code) > bind_rank(top[1:0]))
              break;
            res = {res, make_beat(itp_pkg::KIND_OP, 0, top[1:0])};
            held_cnt--;
          end
          if (held_cnt < itp_pkg::STACK_DEPTH) begin
            held_ops[held_cnt] = {1'b0, t.op_code};
            held_cnt++;
          end else begin
            res = {res, make_beat(itp_pkg::KIND_OVF, 0, 2'd0)};
          end
        end
        itp_pkg::MODE_LPAREN: begin
          if (held_cnt < itp_pkg::STACK_DEPTH) begin
            held_ops[held_cnt] = itp_pkg::LPAREN_MARK;
            held_cnt++;
          end else begin
            res = {res, make_beat(itp_pkg::KIND_OVF, 0, 2'd0)};
          end
        end
        itp_pkg::MODE_RPAREN, itp_pkg::MODE_END: begin
          while (held_cnt > 0 && held_ops[held_cnt-1] != itp_pkg::LPAREN_MARK) begin
            res = {res, make_beat(itp_pkg::KIND_OP, 0, held_ops[held_cnt-1][1:0])};
            held_cnt--;
          end
          if (t.mode == itp_pkg::MODE_END) begin
            held_cnt = 0;
            res = {res, make_beat(itp_pkg::KIND_END, 0, 2'd0)};
          end else if (held_cnt > 0) begin
            held_cnt--;
          end
        end
        default: ;
      endcase
      if (res.size() > 0) res[res.size()-1].last = 1'b1;
      foreach (res[i]) postfix_q = {postfix_q, res[i]};
    endfunction

    function void check_beat(itp_pkg::out_t got);
      itp_pkg::out_t exp_beat;
      if (postfix_q.size() == 0) begin
        $error("unexpected beat: kind %0d value %0d op %0d last %0d",
               got.out_kind, got.out_value, got.out_op, got.last);
        err_count++;
        return;
      end
      exp_beat = postfix_q[0];
      postfix_q.delete(0);
      if (got.out_kind !== exp_beat.out_kind) begin
        $error("out_kind: expected %0d, got %0d", exp_beat.out_kind, got.out_kind);
        err_count++;
      end
      if (got.out_value !== exp_beat.out_value) begin
        $error("out_value: expected %0d, got %0d", exp_beat.out_value, got.out_value);
        err_count++;
      end
      if (got.out_op !== exp_beat.out_op) begin
        $error("out_op: expected %0d, got %0d", exp_beat.out_op, got.out_op);
        err_count++;
      end
      if (got.last !== exp_beat.last) begin
        $error("last: expected %0d, got %0d", exp_beat.last, got.last);
        err_count++;
      end
    endfunction
  endclass

  logic          clk;
  logic          rst;
  logic          in_valid;
  logic          in_stall;
  itp_pkg::in_t  in_data;
  logic          out_valid;
  logic          out_stall;
  itp_pkg::out_t out_data;

  postfix_scoreboard sb = new();
  bit          in_quiet = 1'b0;
  bit          out_quiet = 1'b0;
  int unsigned long_hold_cycles = 0;
  int unsigned sent_cnt = 0;
  int unsigned cycle_count = 0;

  infix_to_postfix_converter u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic itp_pkg::in_t make_token(logic [2:0] m, logic [31:0] v, logic [1:0] op);
    itp_pkg::in_t t;
    t.mode = m;
    t.number_value = v;
    t.op_code = op;
    return t;
  endfunction

  function automatic itp_pkg::in_t rand_token(logic [2:0] m);
    return make_token(m, $urandom, 2'($urandom_range(0, 3)));
  endfunction

  task automatic send_token(itp_pkg::in_t t);
    int unsigned gap;
    gap = in_quiet ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= t;
    do @(posedge clk); while (in_stall);
    sb.note_token(t);
    sent_cnt++;
  endtask

  task automatic send_tokens(input itp_pkg::in_t q[$]);
    foreach (q[i]) send_token(q[i]);
  endtask

  // well-formed expression with random nesting, closed by an end token
  task automatic build_expr(ref itp_pkg::in_t q[$]);
    int depth;
    int len;
    depth = 0;
    len = $urandom_range(1, 8);
    for (int i = 0; i < len; i++) begin
      while (depth < 5 && $urandom_range(0, 3) == 0) begin
        q = {q, rand_token(itp_pkg::MODE_LPAREN)};
        depth++;
      end
      q = {q, rand_token(itp_pkg::MODE_NUM)};
      while (depth > 0 && $urandom_range(0, 2) == 0) begin
        q = {q, rand_token(itp_pkg::MODE_RPAREN)};
        depth--;
      end
      if (i < len - 1) q = {q, rand_token(itp_pkg::MODE_OP)};
    end
    while (depth > 0) begin
      q = {q, rand_token(itp_pkg::MODE_RPAREN)};
      depth--;
    end
    q = {q, rand_token(itp_pkg::MODE_END)};
  endtask

  // paren-heavy run that can drive the stack to full
  task automatic build_deep(ref itp_pkg::in_t q[$]);
    int len;
    int unsigned r;
    len = $urandom_range(18, 30);
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 19);
      if (r < 10) q = {q, rand_token(itp_pkg::MODE_LPAREN)};
      else if (r < 17) q = {q, rand_token(itp_pkg::MODE_OP)};
      else if (r < 19) q = {q, rand_token(itp_pkg::MODE_NUM)};
      else q = {q, rand_token(itp_pkg::MODE_RPAREN)};
    end
    q = {q, rand_token(itp_pkg::MODE_END)};
  endtask

  task automatic build_noise(ref itp_pkg::in_t q[$]);
    int len;
    len = $urandom_range(3, 8);
    for (int i = 0; i < len; i++) q = {q, rand_token(3'($urandom_range(0, 7)))};
  endtask

  initial begin : drain_beats
    int unsigned hold;
    out_stall <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (long_hold_cycles > 0) begin
        hold = long_hold_cycles;
        long_hold_cycles = 0;
      end else begin
        hold = out_quiet ? 0 : $urandom_range(0, 18);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
      sb.check_beat(out_data);
    end
  end

  initial begin : feed_tokens
    itp_pkg::in_t dir_q[$];
    itp_pkg::in_t seq_q[$];
    bit  hold_done;
    bit  pause_done;
    int unsigned pick;
    hold_done = 1'b0;
    pause_done = 1'b0;
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_data <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    dir_q = {dir_q, make_token(itp_pkg::MODE_NUM, 32'h7fffffff, OP_DIV)};
    dir_q = {dir_q, make_token(itp_pkg::MODE_OP, 32'h0, OP_ADD)};
    dir_q = {dir_q, make_token(itp_pkg::MODE_NUM, 32'h80000000, OP_ADD)};
    dir_q = {dir_q, make_token(itp_pkg::MODE_OP, 32'hffffffff, OP_MUL)};
    dir_q = {dir_q, make_token(itp_pkg::MODE_NUM, 32'h0, OP_SUB)};
    dir_q = {dir_q, make_token(itp_pkg::MODE_OP, 32'h0, OP_SUB)};
    dir_q = {dir_q, make_token(itp_pkg::MODE_LPAREN, 32'h0, OP_ADD)};
    dir_q = {dir_q, make_token(itp_pkg::MODE_NUM, 32'hffffffff, OP_MUL)};
    dir_q = {dir_q, make_token(itp_pkg::MODE_OP, 32'h0, OP_DIV)};
    dir_q = {dir_q, make_token(itp_pkg::MODE_NUM, 32'h5, OP_ADD)};
    dir_q = {dir_q, make_token(itp_pkg::MODE_RPAREN, 32'h0, OP_ADD)};
    dir_q = {dir_q, make_token(itp_pkg::MODE_END, 32'h0, OP_ADD)};
    // right paren over an empty stack, then one with no partner
    dir_q = {dir_q, make_token(itp_pkg::MODE_RPAREN, 32'h0, OP_DIV)};
    dir_q = {dir_q, make_token(itp_pkg::MODE_OP, 32'h0, OP_ADD)};
    dir_q = {dir_q, make_token(itp_pkg::MODE_RPAREN, 32'h0, OP_ADD)};
    // unused modes
    dir_q = {dir_q, make_token(3'd5, 32'h12345678, OP_MUL)};
    dir_q = {dir_q, make_token(3'd6, 32'hffffffff, OP_DIV)};
    dir_q = {dir_q, make_token(3'd7, 32'h0, OP_SUB)};
    // unclosed left paren at end of expression
    dir_q = {dir_q, make_token(itp_pkg::MODE_LPAREN, 32'h0, OP_ADD)};
    dir_q = {dir_q, make_token(itp_pkg::MODE_OP, 32'h0, OP_ADD)};
    dir_q = {dir_q, make_token(itp_pkg::MODE_LPAREN, 32'h0, OP_ADD)};
    dir_q = {dir_q, make_token(itp_pkg::MODE_OP, 32'h0, OP_MUL)};
    dir_q = {dir_q, make_token(itp_pkg::MODE_END, 32'h0, OP_ADD)};
    send_tokens(dir_q);

    while (sent_cnt < TOKEN_TARGET) begin
      in_quiet = ($urandom_range(0, 3) == 0);
      out_quiet = ($urandom_range(0, 3) == 0);
      if (!hold_done && sent_cnt >= 60) begin
        hold_done = 1'b1;
        long_hold_cycles = LONG_HOLD;
      end
      if (!pause_done && sent_cnt >= 140) begin
        pause_done = 1'b1;
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
      end
      seq_q.delete();
      pick = $urandom_range(0, 9);
      if (pick < 6) build_expr(seq_q);
      else if (pick < 8) build_deep(seq_q);
      else build_noise(seq_q);
      send_tokens(seq_q);
    end

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.err_count == 0 && sb.pending() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
